// File: design/biquad_pkg.sv
package biquad_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int COEF_WIDTH   = 32;
    localparam int STATE_WIDTH  = 48;
    localparam int SAMPLE_FRAC  = SAMPLE_WIDTH - 1;
    localparam int COEF_FRAC    = COEF_WIDTH - 4;
    localparam int STATE_FRAC   = STATE_WIDTH - 8;
    localparam int NUM_COEFS    = 5;
    localparam int CFG_INDEX_WIDTH = 3;

    // Alignment of a sample product to the accumulator scale.
    localparam int FEED_SHIFT  = STATE_FRAC - SAMPLE_FRAC;
    // Rounding shift from the state format down to the sample format.
    localparam int OUT_SHIFT   = STATE_FRAC - SAMPLE_FRAC;

    // The state word is split in halves so that each product fits the shared multiplier.
    localparam int YLO_WIDTH   = STATE_WIDTH / 2;
    localparam int YHI_WIDTH   = STATE_WIDTH - YLO_WIDTH;
    localparam int MUL_A_WIDTH = YLO_WIDTH + 1;
    localparam int PROD_WIDTH  = MUL_A_WIDTH + COEF_WIDTH;
    localparam int ACC_WIDTH   = STATE_WIDTH + COEF_WIDTH + 4;

    localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } coef_idx_t;

    typedef logic signed [ACC_WIDTH-1:0]    acc_t;
    typedef logic signed [STATE_WIDTH-1:0]  state_word_t;
    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [PROD_WIDTH-1:0]   prod_t;

    localparam acc_t ROUND_ACC = ACC_WIDTH'(1) << (COEF_FRAC - 1);

    // Round half up from accumulator scale to the state format, then saturate.
    function automatic state_word_t to_state(input acc_t a);
        acc_t t;
        acc_t st_max;
        acc_t st_min;
        st_max = {{(ACC_WIDTH - STATE_WIDTH + 1){1'b0}}, {(STATE_WIDTH - 1){1'b1}}};
        st_min = ~st_max;
        t = a + ROUND_ACC;
        t = t >>> COEF_FRAC;
        if (t > st_max)
        begin
            t = st_max;
        end
        else if (t < st_min)
        begin
            t = st_min;
        end
        return t[STATE_WIDTH-1:0];
    endfunction

    // Round half up from the state format to the sample format, then saturate.
    function automatic sample_t to_sample(input state_word_t y);
        logic signed [STATE_WIDTH:0] t;
        logic signed [STATE_WIDTH:0] rnd;
        logic signed [STATE_WIDTH:0] s_max;
        logic signed [STATE_WIDTH:0] s_min;
        rnd   = (STATE_WIDTH + 1)'(1) << (OUT_SHIFT - 1);
        s_max = {{(STATE_WIDTH - SAMPLE_WIDTH + 2){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
        s_min = ~s_max;
        t = {y[STATE_WIDTH-1], y} + rnd;
        t = t >>> OUT_SHIFT;
        if (t > s_max)
        begin
            t = s_max;
        end
        else if (t < s_min)
        begin
            t = s_min;
        end
        return t[SAMPLE_WIDTH-1:0];
    endfunction

    function automatic acc_t ext_prod(input prod_t p);
        return {{(ACC_WIDTH - PROD_WIDTH){p[PROD_WIDTH-1]}}, p};
    endfunction

    function automatic acc_t ext_state(input state_word_t z);
        return {{(ACC_WIDTH - STATE_WIDTH){z[STATE_WIDTH-1]}}, z};
    endfunction

endpackage

// File: design/biquad_iir_filter.sv
// Second-order IIR section, transposed direct form II, Q1.23 samples in and out.
// Input samples arrive on the s_* stream; s_tlast carries the block-end flag and
// reappears unchanged on m_tlast with the matching result on the m_* stream.
// Coefficients b0, b1, b2, a1, a2 (Q4.28) are written on the cfg_* channel at
// index 0 to 4; cfg_ready is always high and other indexes are ignored. Write
// them only while no request is in flight.
// One shared 25x32 signed multiplier and one wide accumulator are stepped
// through ten sequencer states per sample (the y*a products take two passes
// each, low and high half of y). A sample is accepted only in the idle state,
// so a new sample is not taken until the last one has left the final state;
// the result is registered onto m_tvalid as the sequencer leaves that state.
// The output register lets a new sample be taken while a result waits; if the
// receiver stalls, the sequencer holds in its last state until the output
// register frees up, and the input side stalls in turn.
// Reset clears the delay words, restores the passthrough coefficients
// (b0 = 1.0, the rest 0) and empties the output register.
module biquad_iir_filter
    import biquad_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [SAMPLE_WIDTH-1:0]    s_tdata,   // [23:0] sample_in
    input  logic                       s_tlast,   // block_end_in
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [SAMPLE_WIDTH-1:0]    m_tdata,   // [23:0] sample_out
    output logic                       m_tlast,   // block_end_out
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COEF_WIDTH-1:0]      cfg_data
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_B0   = 11'b00000000010,
        S_B1   = 11'b00000000100,
        S_Y    = 11'b00000001000,
        S_A1L  = 11'b00000010000,
        S_A1H  = 11'b00000100000,
        S_B2   = 11'b00001000000,
        S_N1   = 11'b00010000000,
        S_A2H  = 11'b00100000000,
        S_N2   = 11'b01000000000,
        S_DONE = 11'b10000000000
    } state_t;

    typedef enum logic [1:0] {
        OPA_X,
        OPA_YLO,
        OPA_YHI
    } opa_sel_t;

    state_t                  state_reg, state_next;
    logic [COEF_WIDTH-1:0]   coef_reg [NUM_COEFS];
    sample_t                 x_reg, x_next;
    logic                    last_reg, last_next;
    state_word_t             z1_reg, z1_next;
    state_word_t             z2_reg, z2_next;
    state_word_t             y_reg, y_next;
    acc_t                    acc_reg, acc_next;
    prod_t                   prod_reg, prod_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_WIDTH-1:0] m_tdata_reg, m_tdata_next;
    logic                    m_tlast_reg, m_tlast_next;

    opa_sel_t                opa_sel;
    coef_idx_t               coef_sel;
    logic signed [MUL_A_WIDTH-1:0] mul_a;
    logic signed [COEF_WIDTH-1:0]  mul_b;
    acc_t                    prod_feed;
    acc_t                    prod_lo;
    acc_t                    prod_hi;
    logic                    out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Shared multiplier.
    always_comb
    begin
        case (opa_sel)
            OPA_X:   mul_a = {{(MUL_A_WIDTH - SAMPLE_WIDTH){x_reg[SAMPLE_WIDTH-1]}}, x_reg};
            OPA_YLO: mul_a = {1'b0, y_reg[YLO_WIDTH-1:0]};
            OPA_YHI: mul_a = {{(MUL_A_WIDTH - YHI_WIDTH){y_reg[STATE_WIDTH-1]}},
                              y_reg[STATE_WIDTH-1:YLO_WIDTH]};
            default: mul_a = '0;
        endcase
        mul_b     = coef_reg[coef_sel];
        prod_next = mul_a * mul_b;
    end

    assign prod_lo   = ext_prod(prod_reg);
    assign prod_feed = prod_lo <<< FEED_SHIFT;
    assign prod_hi   = prod_lo <<< YLO_WIDTH;

    always_comb
    begin
        state_next    = state_reg;
        x_next        = x_reg;
        last_next     = last_reg;
        z1_next       = z1_reg;
        z2_next       = z2_reg;
        y_next        = y_reg;
        acc_next      = acc_reg;
        opa_sel       = OPA_X;
        coef_sel      = COEF_B0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next     = s_tdata;
                    last_next  = s_tlast;
                    state_next = S_B0;
                end
            end
            S_B0:
            begin
                acc_next   = ext_state(z1_reg) <<< COEF_FRAC;
                state_next = S_B1;
            end
            S_B1:
            begin
                acc_next   = acc_reg + prod_feed;
                coef_sel   = COEF_B1;
                state_next = S_Y;
            end
            S_Y:
            begin
                y_next     = to_state(acc_reg);
                acc_next   = (ext_state(z2_reg) <<< COEF_FRAC) + prod_feed;
                state_next = S_A1L;
            end
            S_A1L:
            begin
                opa_sel    = OPA_YLO;
                coef_sel   = COEF_A1;
                state_next = S_A1H;
            end
            S_A1H:
            begin
                acc_next   = acc_reg - prod_lo;
                opa_sel    = OPA_YHI;
                coef_sel   = COEF_A1;
                state_next = S_B2;
            end
            S_B2:
            begin
                acc_next   = acc_reg - prod_hi;
                coef_sel   = COEF_B2;
                state_next = S_N1;
            end
            S_N1:
            begin
                z1_next    = to_state(acc_reg);
                acc_next   = prod_feed;
                opa_sel    = OPA_YLO;
                coef_sel   = COEF_A2;
                state_next = S_A2H;
            end
            S_A2H:
            begin
                acc_next   = acc_reg - prod_lo;
                opa_sel    = OPA_YHI;
                coef_sel   = COEF_A2;
                state_next = S_N2;
            end
            S_N2:
            begin
                acc_next   = acc_reg - prod_hi;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    z2_next       = to_state(acc_reg);
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = to_sample(y_reg);
                    m_tlast_next  = last_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            z1_reg       <= '0;
            z2_reg       <= '0;
            coef_reg[COEF_B0] <= COEF_ONE;
            coef_reg[COEF_B1] <= '0;
            coef_reg[COEF_B2] <= '0;
            coef_reg[COEF_A1] <= '0;
            coef_reg[COEF_A2] <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            z1_reg       <= z1_next;
            z2_reg       <= z2_next;
            if (cfg_valid && (cfg_index < CFG_INDEX_WIDTH'(NUM_COEFS)))
            begin
                coef_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        last_reg    <= last_next;
        y_reg       <= y_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // An accepted request always starts the multiply sequence.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_B0)
        else $error("accepted request did not start the sequence");

    // Leaving the final state always presents a result.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_free |=> m_tvalid && state_reg == S_IDLE)
        else $error("finished request did not produce a result");

    // A stalled result holds the sequencer in its final state.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && m_tvalid && !m_tready |=> state_reg == S_DONE)
        else $error("sequencer overran a stalled result");

    // A coefficient write to a1 lands in its register.
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == COEF_A1 |=> coef_reg[COEF_A1] == $past(cfg_data))
        else $error("coefficient write lost");

endmodule
